>>> hdl/ctc_pkg.sv
`default_nettype none

package ctc_pkg;

   localparam int COUNT_BITS = 16;
   localparam int ENTRY_BITS = 4;
   localparam int CLASS_BITS = 4;
   localparam int MASK_BITS  = 27;
   localparam logic [MASK_BITS-1:0] MASK_RESET = 27'd12812800;
   localparam int CHANNELS   = 3;

   typedef enum logic {
      CMD_CLASSIFY  = 1'b0,
      CMD_CALIBRATE = 1'b1
   } cmd_type;

endpackage

`default_nettype wire

>>> hdl/ctc_if.sv
`default_nettype none

interface ctc_req_if;
   import ctc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [ENTRY_BITS-1:0] entry_index;
   logic [COUNT_BITS-1:0] red_count;
   logic [COUNT_BITS-1:0] green_count;
   logic [COUNT_BITS-1:0] blue_count;
   logic [COUNT_BITS-1:0] clear_count;
   modport source (output valid, cmd, entry_index, red_count, green_count, blue_count,
                   clear_count, input ready);
   modport sink (input valid, cmd, entry_index, red_count, green_count, blue_count,
                 clear_count, output ready);
endinterface

interface ctc_rsp_if;
   import ctc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CLASS_BITS-1:0] color_class;
   modport source (output valid, color_class, input ready);
   modport sink (input valid, color_class, output ready);
endinterface

interface ctc_csr_if;
   import ctc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [MASK_BITS-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hdl/color_template_classifier.sv
`default_nettype none

// Color template classifier.
// The req_port channel carries one sensor sample per transaction: a command
// (classify or calibrate), a table entry index and the red, green, blue and
// clear counts. Three serial dividers form the channel-over-clear ratios.
// A calibrate transaction then writes the ratios into the template memory,
// if its entry index is below NUM_COLORS, and produces no result. A classify
// transaction reads the NUM_COLORS templates from the memory one per cycle,
// compares each against its window, and puts one color_class transaction on
// rsp_port. The serial division takes most of the time an item occupies the
// block. req_port is ready whenever no item is in progress. A result waits
// in an output register, so the next sample is accepted while the receiver
// stalls; only the hand-off of the following result waits for rsp_port to
// drain. The csr_port channel is always ready and writes the narrow window
// mask. Reset restores the mask and makes every template read as one half.

module color_template_classifier #(
   parameter int NUM_COLORS      = 9,
   parameter int RATIO_FRAC_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   ctc_req_if.sink   req_port,
   ctc_rsp_if.source rsp_port,
   ctc_csr_if.sink   csr_port
);
   import ctc_pkg::*;

   localparam int RB       = RATIO_FRAC_BITS + 2;
   localparam int PW       = RB + 7;
   localparam int QW       = COUNT_BITS + RATIO_FRAC_BITS;
   localparam int CNT_W    = $clog2(QW);
   localparam int IDX_W    = $clog2(NUM_COLORS);
   localparam int MW       = (NUM_COLORS * 3 > MASK_BITS) ? NUM_COLORS * 3 : MASK_BITS;
   localparam int MI_W     = $clog2(MW);
   localparam int ROW_BITS = CHANNELS * RB;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   state_type             state_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  cmd_ff;
   logic [ENTRY_BITS-1:0] entry_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  cmp_valid_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic [CLASS_BITS-1:0] best_ff;
   logic                  rsp_valid_ff;
   logic [CLASS_BITS-1:0] rsp_class_ff;
   logic [MASK_BITS-1:0]  mask_ff;
   logic [NUM_COLORS-1:0] row_valid_ff;
   logic                  rd_row_valid_ff;
   logic [ROW_BITS-1:0]   rd_data_ff;
   logic [ROW_BITS-1:0]   mem [NUM_COLORS];

   logic                  accept;
   logic                  div_load;
   logic                  div_step;
   logic                  mem_we;
   logic                  mem_re;
   logic                  rsp_load;
   logic [RB-1:0]         ratio [CHANNELS];
   logic [ROW_BITS-1:0]   ratio_row;
   logic [ROW_BITS-1:0]   tmpl_row;
   logic [MW-1:0]         mask_wide;
   logic [CHANNELS-1:0]   chan_ok;
   logic                  entry_in_range;

   assign accept         = req_port.valid && req_port.ready;
   assign req_port.ready = state_ff == ST_IDLE;
   assign div_load       = accept;
   assign div_step       = state_ff == ST_DIVIDE;
   assign entry_in_range = {1'b0, entry_ff} < (ENTRY_BITS + 1)'(NUM_COLORS);
   assign mem_we         = state_ff == ST_WRITE && entry_in_range;
   assign mem_re         = state_ff == ST_SCAN;
   assign rsp_load       = state_ff == ST_RESULT && (!rsp_valid_ff || rsp_port.ready);

   assign csr_port.ready       = 1'b1;
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.color_class = rsp_class_ff;

   ctc_divider #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_div_red (
      .clock(clock), .load(div_load), .step(div_step),
      .count(req_port.red_count), .divisor(req_port.clear_count), .ratio(ratio[0])
   );

   ctc_divider #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_div_green (
      .clock(clock), .load(div_load), .step(div_step),
      .count(req_port.green_count), .divisor(req_port.clear_count), .ratio(ratio[1])
   );

   ctc_divider #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_div_blue (
      .clock(clock), .load(div_load), .step(div_step),
      .count(req_port.blue_count), .divisor(req_port.clear_count), .ratio(ratio[2])
   );

   assign ratio_row = {ratio[2], ratio[1], ratio[0]};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[entry_ff[IDX_W-1:0]] <= ratio_row;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_idx_ff];
      end
   end

   assign tmpl_row  = rd_row_valid_ff ? rd_data_ff
                                      : {CHANNELS{RB'(1) << (RATIO_FRAC_BITS - 1)}};
   assign mask_wide = MW'(mask_ff);

   for (genvar c = 0; c < CHANNELS; c++) begin : g_cmp
      logic [RB-1:0]   x;
      logic [RB-1:0]   t;
      logic [MI_W-1:0] bit_idx;
      logic [PW-1:0]   x10, x100, t9, t11, t95, t105;
      logic            wide_ok, narrow_ok;

      assign x         = ratio[c];
      assign t         = tmpl_row[c*RB +: RB];
      assign bit_idx   = MI_W'(MI_W'(cmp_idx_ff) * MI_W'(3) + MI_W'(c));
      assign x10       = PW'(x) * PW'(10);
      assign x100      = PW'(x) * PW'(100);
      assign t9        = PW'(t) * PW'(9);
      assign t11       = PW'(t) * PW'(11);
      assign t95       = PW'(t) * PW'(95);
      assign t105      = PW'(t) * PW'(105);
      assign wide_ok   = (x10 < t11) && (x10 > t9);
      assign narrow_ok = (x100 < t105) && (x100 > t95);
      assign chan_ok[c] = mask_wide[bit_idx] ? narrow_ok : wide_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cnt_ff          <= '0;
         rd_idx_ff       <= '0;
         cmp_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         mask_ff         <= MASK_RESET;
         row_valid_ff    <= '0;
         rd_row_valid_ff <= 1'b0;
      end else begin
         if (csr_port.valid) begin
            mask_ff <= csr_port.data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         cmp_valid_ff <= mem_re;
         cmp_idx_ff   <= rd_idx_ff;
         if (mem_re) begin
            rd_row_valid_ff <= row_valid_ff[rd_idx_ff];
         end
         if (cmp_valid_ff && (&chan_ok)) begin
            best_ff <= CLASS_BITS'({1'b0, cmp_idx_ff} + (IDX_W + 1)'(1));
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  cmd_ff    <= req_port.cmd;
                  entry_ff  <= req_port.entry_index;
                  cnt_ff    <= '0;
                  rd_idx_ff <= '0;
                  best_ff   <= '0;
                  state_ff  <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(QW - 1)) begin
                  state_ff <= (cmd_ff == CMD_CALIBRATE) ? ST_WRITE : ST_SCAN;
               end
            end
            ST_WRITE: begin
               if (entry_in_range) begin
                  row_valid_ff[entry_ff[IDX_W-1:0]] <= 1'b1;
               end
               state_ff <= ST_IDLE;
            end
            ST_SCAN: begin
               rd_idx_ff <= rd_idx_ff + IDX_W'(1);
               if (rd_idx_ff == IDX_W'(NUM_COLORS - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (rsp_load) begin
                  rsp_class_ff <= best_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> hdl/ctc_divider.sv
`default_nettype none

module ctc_divider #(
   parameter int RATIO_FRAC_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire logic                           step,
   input  wire logic [ctc_pkg::COUNT_BITS-1:0] count,
   input  wire logic [ctc_pkg::COUNT_BITS-1:0] divisor,
   output logic      [RATIO_FRAC_BITS+1:0]     ratio
);
   import ctc_pkg::*;

   localparam int RB = RATIO_FRAC_BITS + 2;
   localparam int QW = COUNT_BITS + RATIO_FRAC_BITS;

   logic [QW-1:0]         dividend_ff;
   logic [QW-1:0]         quot_ff;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [COUNT_BITS-1:0] divisor_ff;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;

   assign trial = {rem_ff, dividend_ff[QW-1]};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_ff @(posedge clock) begin
      if (load) begin
         dividend_ff <= {count, {RATIO_FRAC_BITS{1'b0}}};
         quot_ff     <= '0;
         rem_ff      <= '0;
         divisor_ff  <= divisor;
      end else if (step) begin
         dividend_ff <= {dividend_ff[QW-2:0], 1'b0};
         quot_ff     <= {quot_ff[QW-2:0], fits};
         if (fits) begin
            rem_ff <= COUNT_BITS'(trial - {1'b0, divisor_ff});
         end else begin
            rem_ff <= trial[COUNT_BITS-1:0];
         end
      end
   end

   // A zero divisor yields an all-ones quotient, which saturates below.
   assign ratio = (|quot_ff[QW-1:RB]) ? {RB{1'b1}} : quot_ff[RB-1:0];

endmodule

`default_nettype wire
